// ===== rtl/tcce_pkg.sv =====
`default_nettype none
package tcce_pkg;
    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;
    localparam int CELL_W = 16;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] LAST_PRINTABLE = 8'd127;
    localparam logic [15:0] SCROLL_FILL = 16'h0F20;
    localparam logic [7:0] CR_CODE = 8'd13;
    localparam logic [7:0] LF_CODE = 8'd10;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_SET   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_ATTR  = 3'd0,
        REG_BS    = 3'd1,
        REG_TAB   = 3'd2,
        REG_ENTER = 3'd3,
        REG_LEFT  = 3'd4,
        REG_RIGHT = 3'd5,
        REG_HOME  = 3'd6,
        REG_DEL   = 3'd7
    } reg_idx_t;

    // copy/fill sweep kinds
    typedef enum logic [1:0] {
        SW_DELETE = 2'd0,
        SW_SCROLL = 2'd1,
        SW_CLEAR  = 2'd2
    } sweep_t;

    typedef struct packed {
        logic   start;
        logic   write_char;
        logic   read_cell;
        sweep_t kind;
        logic   load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic   need_sweep;
        sweep_t kind;
        logic   sweep_done;
        logic   read_done;
        logic   read_is_cell;
    } ctl_sts_t;
endpackage
`default_nettype wire

// ===== rtl/tcce_if.sv =====
`default_nettype none
interface tcce_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] char_code;
    logic [6:0] pos_col;
    logic [4:0] pos_row;
    modport source (output valid, op, char_code, pos_col, pos_row, input ready);
    modport sink (input valid, op, char_code, pos_col, pos_row, output ready);
endinterface

interface tcce_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_addr;
    logic [15:0] cell_value;
    modport source (output valid, cursor_col, cursor_row, cursor_addr, cell_value,
                    input ready);
    modport sink (input valid, cursor_col, cursor_row, cursor_addr, cell_value,
                  output ready);
endinterface

interface tcce_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tcce_ram.sv =====
`default_nettype none
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/tcce_ctrl.sv =====
`default_nettype none
module tcce_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          in_op,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tcce_pkg::ctl_cmd_t       cmd,
    input  wire tcce_pkg::ctl_sts_t  sts
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_READ  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic [1:0] op_reg, op_next;
    logic   accept, finish, out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        finish     = 1'b0;
        cmd        = '0;
        cmd.start  = accept;
        cmd.kind   = sts.kind;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // hold the item until the out register is free
                if (!out_free)
                begin
                    state_next = S_EVAL;
                end
                else if (op_reg == tcce_pkg::OP_READ)
                begin
                    cmd.read_cell = 1'b1;
                    state_next    = S_READ;
                end
                else if (sts.need_sweep)
                begin
                    cmd.write_char = 1'b1;
                    state_next     = S_SWEEP;
                end
                else
                begin
                    cmd.write_char = 1'b1;
                    finish         = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SWEEP:
            begin
                if (sts.sweep_done)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (sts.read_done)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        cmd.load_out = finish;
    end

    always_comb
    begin
        op_next        = accept ? in_op : op_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= tcce_pkg::OP_PUT;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tcce_dp.sv =====
`default_nettype none
module tcce_dp #(
    parameter int COLS = tcce_pkg::COLS_DEF,
    parameter int ROWS = tcce_pkg::ROWS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         op,
    input  wire logic [7:0]         char_code,
    input  wire logic [6:0]         pos_col,
    input  wire logic [4:0]         pos_row,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire tcce_pkg::ctl_cmd_t cmd,
    output tcce_pkg::ctl_sts_t      sts,
    output logic [6:0]              cursor_col,
    output logic [4:0]              cursor_row,
    output logic [10:0]             cursor_addr,
    output logic [15:0]             cell_value
);
    localparam int CELLS = COLS * ROWS;
    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(COLS + 1);
    localparam int RW = $clog2(ROWS + 1);

    logic [7:0] attr_reg, bs_reg, tab_reg, enter_reg;
    logic [7:0] left_reg, right_reg, home_reg, del_reg;
    logic [1:0] op_reg;
    logic [7:0] code_reg;
    logic [6:0] pcol_reg;
    logic [4:0] prow_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // sweep state
    logic [AW-1:0] sw_addr_reg;
    logic [AW-1:0] sw_end_reg;
    logic          sw_phase_reg;
    tcce_pkg::sweep_t kind_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic [15:0]   blank;
    logic [AW-1:0] cur_idx;

    // next cursor for put character
    logic          is_print, do_del, do_back;
    logic [CW:0]   col_w;
    logic [RW:0]   row_w;
    logic          need_sweep;
    tcce_pkg::sweep_t kind_w;
    logic [CW-1:0] back_col;
    logic [RW-1:0] back_row;
    logic [AW-1:0] del_idx;

    // first read of a copy sweep is issued while the write side starts
    logic [AW-1:0] first_rd;

    assign blank   = {attr_reg, tcce_pkg::BLANK_CHAR};
    assign cur_idx = AW'(32'(row_reg) * COLS + 32'(col_reg));

    always_comb
    begin
        back_col = col_reg;
        back_row = row_reg;
        if (col_reg != '0)
        begin
            back_col = col_reg - 1'b1;
        end
        else if (row_reg > RW'(1))
        begin
            back_col = CW'(COLS - 1);
            back_row = row_reg - 1'b1;
        end
    end

    always_comb
    begin
        is_print = (code_reg >= tcce_pkg::BLANK_CHAR) &&
                   (code_reg <= tcce_pkg::LAST_PRINTABLE);
        do_del  = 1'b0;
        do_back = 1'b0;
        col_w   = {1'b0, col_reg};
        row_w   = {1'b0, row_reg};
        if (is_print)
        begin
            col_w = {1'b0, col_reg} + 1'b1;
        end
        else if (code_reg == bs_reg)
        begin
            do_back = 1'b1;
            do_del  = 1'b1;
            col_w   = {1'b0, back_col};
            row_w   = {1'b0, back_row};
        end
        else if (code_reg == left_reg)
        begin
            col_w = {1'b0, back_col};
            row_w = {1'b0, back_row};
        end
        else if (code_reg == right_reg)
        begin
            col_w = {1'b0, col_reg} + 1'b1;
        end
        else if (code_reg == tab_reg)
        begin
            col_w = ({1'b0, col_reg} + (CW+1)'(8)) & ~(CW+1)'(7);
        end
        else if (code_reg == tcce_pkg::CR_CODE || code_reg == home_reg)
        begin
            col_w = '0;
        end
        else if (code_reg == del_reg)
        begin
            do_del = 1'b1;
        end
        else if (code_reg == tcce_pkg::LF_CODE || code_reg == enter_reg)
        begin
            col_w = '0;
            row_w = {1'b0, row_reg} + 1'b1;
        end
        if (col_w >= (CW+1)'(COLS))
        begin
            col_w = '0;
            row_w = row_w + 1'b1;
        end
        del_idx = AW'(32'(do_back ? back_row : row_reg) * COLS
                      + 32'(do_back ? back_col : col_reg));
        need_sweep = 1'b0;
        kind_w     = tcce_pkg::SW_DELETE;
        if (op_reg == tcce_pkg::OP_CLEAR)
        begin
            need_sweep = 1'b1;
            kind_w     = tcce_pkg::SW_CLEAR;
        end
        else if (op_reg == tcce_pkg::OP_PUT)
        begin
            if (do_del)
            begin
                need_sweep = 1'b1;
                kind_w     = tcce_pkg::SW_DELETE;
            end
            else if (row_w >= (RW+1)'(ROWS))
            begin
                need_sweep = 1'b1;
                kind_w     = tcce_pkg::SW_SCROLL;
            end
        end
    end

    // delete ending in a row overflow cannot happen: step back never raises the row
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.write_char)
        begin
            unique case (op_reg)
                tcce_pkg::OP_PUT:
                begin
                    col_next = col_w[CW-1:0];
                    row_next = (row_w >= (RW+1)'(ROWS)) ? RW'(ROWS - 1) : row_w[RW-1:0];
                end
                tcce_pkg::OP_CLEAR:
                begin
                    col_next = '0;
                    row_next = RW'(1);
                end
                tcce_pkg::OP_SET:
                begin
                    col_next = (32'(pcol_reg) < COLS) ? CW'(pcol_reg) : CW'(COLS - 1);
                    if (prow_reg == '0)
                    begin
                        row_next = RW'(1);
                    end
                    else if (32'(prow_reg) > ROWS - 1)
                    begin
                        row_next = RW'(ROWS - 1);
                    end
                    else
                    begin
                        row_next = RW'(prow_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    assign first_rd = (kind_w == tcce_pkg::SW_SCROLL) ? AW'(2 * COLS) : del_idx + 1'b1;

    logic sw_last;
    assign sw_last = (sw_addr_reg == sw_end_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sw_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = cmd.write_char ? first_rd : sw_addr_reg;
        if (cmd.write_char && op_reg == tcce_pkg::OP_PUT && is_print &&
            cur_idx < AW'(CELLS))
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_idx;
            ram_wdata = {attr_reg, code_reg};
        end
        else if (cmd.read_cell)
        begin
            ram_raddr = AW'(32'(prow_reg) * COLS + 32'(pcol_reg));
        end
        else if (sw_phase_reg)
        begin
            unique case (kind_reg)
                tcce_pkg::SW_CLEAR:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = blank;
                end
                tcce_pkg::SW_SCROLL:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = (sw_addr_reg >= AW'((ROWS - 1) * COLS)) ?
                                tcce_pkg::SCROLL_FILL : ram_rdata;
                    ram_raddr = sw_addr_reg + AW'(COLS + 1);
                end
                tcce_pkg::SW_DELETE:
                begin
                    ram_we    = 1'b1;
                    ram_wdata = sw_last ? blank : ram_rdata;
                    ram_raddr = sw_addr_reg + AW'(2);
                end
                default: ;
            endcase
        end
    end

    tcce_ram #(.WIDTH(tcce_pkg::CELL_W), .DEPTH(CELLS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic read_wait_reg;
    logic read_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= 8'd15;
            bs_reg        <= 8'd8;
            tab_reg       <= 8'd9;
            enter_reg     <= 8'd10;
            left_reg      <= 8'd128;
            right_reg     <= 8'd129;
            home_reg      <= 8'd130;
            del_reg       <= 8'd131;
            col_reg       <= '0;
            row_reg       <= RW'(1);
            sw_phase_reg  <= 1'b0;
            read_wait_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (tcce_pkg::reg_idx_t'(cfg_index))
                    tcce_pkg::REG_ATTR:  attr_reg  <= cfg_data;
                    tcce_pkg::REG_BS:    bs_reg    <= cfg_data;
                    tcce_pkg::REG_TAB:   tab_reg   <= cfg_data;
                    tcce_pkg::REG_ENTER: enter_reg <= cfg_data;
                    tcce_pkg::REG_LEFT:  left_reg  <= cfg_data;
                    tcce_pkg::REG_RIGHT: right_reg <= cfg_data;
                    tcce_pkg::REG_HOME:  home_reg  <= cfg_data;
                    tcce_pkg::REG_DEL:   del_reg   <= cfg_data;
                    default: ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            read_wait_reg <= cmd.read_cell;
            if (cmd.write_char && need_sweep)
            begin
                sw_phase_reg <= 1'b1;
            end
            else if (sw_phase_reg && sw_last)
            begin
                sw_phase_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            code_reg <= char_code;
            pcol_reg <= pos_col;
            prow_reg <= pos_row;
        end
        if (cmd.write_char)
        begin
            kind_reg <= kind_w;
            unique case (kind_w)
                tcce_pkg::SW_CLEAR:
                begin
                    sw_addr_reg <= AW'(COLS);
                    sw_end_reg  <= AW'(CELLS - 1);
                end
                tcce_pkg::SW_SCROLL:
                begin
                    sw_addr_reg <= AW'(COLS);
                    sw_end_reg  <= AW'(CELLS - 1);
                end
                default:
                begin
                    sw_addr_reg <= del_idx;
                    sw_end_reg  <= AW'(CELLS - 1);
                end
            endcase
        end
        else if (sw_phase_reg)
        begin
            sw_addr_reg <= sw_addr_reg + 1'b1;
        end
        if (cmd.read_cell)
        begin
            read_ok_reg <= (32'(prow_reg) < ROWS) && (32'(pcol_reg) < COLS);
        end
        if (cmd.load_out)
        begin
            cursor_col  <= 7'(col_next);
            cursor_row  <= 5'(row_next);
            cursor_addr <= 11'(32'(row_next) * COLS + 32'(col_next));
            cell_value  <= (read_wait_reg && read_ok_reg) ? ram_rdata : 16'h0000;
        end
    end

    assign sts.need_sweep   = need_sweep;
    assign sts.kind         = kind_w;
    assign sts.sweep_done   = sw_phase_reg && sw_last;
    assign sts.read_done    = read_wait_reg;
    assign sts.read_is_cell = read_ok_reg;
endmodule
`default_nettype wire

// ===== rtl/text_console_char_engine_unit.sv =====
// text console character engine
// channels: in (op, char_code, pos_col, pos_row), out (cursor and cell read),
// cfg (register index and data, always ready)
// one beat in gives exactly one beat out; one item is worked at a time
// after the in beat is taken, a print, cursor move or unknown code waits in
// S_EVAL for a free out register and the out beat is loaded as it leaves;
// a read goes on through S_READ first. a clear or scroll sweeps rows 1 to
// rows-1 one cell per cycle, a delete sweeps from the cursor index to the
// screen end, and the out beat is loaded as the sweep ends
// the next in beat is taken only once the out beat is loaded, so a new item
// is not taken before the last one is through
// reset puts the cursor at column 0, row 1 and loads the default codes;
// the cell store is not cleared and holds junk until written
// an in beat is taken while the out beat waits; its work then holds until
// the waiting out beat is taken
// configure only while idle
`default_nettype none
module text_console_char_engine_unit #(
    parameter int COLS = tcce_pkg::COLS_DEF,
    parameter int ROWS = tcce_pkg::ROWS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    tcce_in_if.sink    in,
    tcce_out_if.source out,
    tcce_cfg_if.sink   cfg
);
    tcce_pkg::ctl_cmd_t cmd;
    tcce_pkg::ctl_sts_t sts;

    assign cfg.ready = 1'b1;

    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .in_op     (in.op),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    tcce_dp #(.COLS(COLS), .ROWS(ROWS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.start),
        .op          (in.op),
        .char_code   (in.char_code),
        .pos_col     (in.pos_col),
        .pos_row     (in.pos_row),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .cmd         (cmd),
        .sts         (sts),
        .cursor_col  (out.cursor_col),
        .cursor_row  (out.cursor_row),
        .cursor_addr (out.cursor_addr),
        .cell_value  (out.cell_value)
    );
endmodule
`default_nettype wire

// ===== tb/tcce_tb_if.sv =====
`timescale 1ns / 1ps
// interfaces come from the rtl folder; this file only holds the result record
package tcce_tb_pkg;
    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] addr;
        logic [15:0] cell_val;
    } cursor_beat_t;
endpackage

// ===== tb/tcce_checker.sv =====
`timescale 1ns / 1ps
module tcce_checker
    import tcce_pkg::*;
    import tcce_tb_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    tcce_in_if in,
    tcce_out_if out,
    tcce_cfg_if cfg,
    output int fail_count,
    output int pending
);
    localparam int NC = COLS_DEF;
    localparam int NR = ROWS_DEF;
    localparam int NCELL = NC * NR;

    logic [15:0] screen [NCELL];
    int cur_col;
    int cur_row;
    logic [7:0] regs [8];
    cursor_beat_t expected_q [$];

    function automatic logic [15:0] blank();
        return {regs[REG_ATTR], BLANK_CHAR};
    endfunction

    task automatic retreat();
        if (cur_col != 0)
            cur_col--;
        else if (cur_row > 1)
        begin
            cur_col = NC - 1;
            cur_row--;
        end
    endtask

    task automatic shift_out_cell();
        for (int i = cur_row * NC + cur_col; i + 1 < NCELL; i++)
            screen[i] = screen[i + 1];
        screen[NCELL - 1] = blank();
    endtask

    task automatic print_code(logic [7:0] c);
        if (c >= BLANK_CHAR && c <= LAST_PRINTABLE)
        begin
            screen[cur_row * NC + cur_col] = {regs[REG_ATTR], c};
            cur_col++;
        end
        else if (c == regs[REG_BS])
        begin
            retreat();
            shift_out_cell();
        end
        else if (c == regs[REG_LEFT])
            retreat();
        else if (c == regs[REG_RIGHT])
            cur_col++;
        else if (c == regs[REG_TAB])
            cur_col = (cur_col + 8) & ~7;
        else if (c == CR_CODE || c == regs[REG_HOME])
            cur_col = 0;
        else if (c == regs[REG_DEL])
            shift_out_cell();
        else if (c == LF_CODE || c == regs[REG_ENTER])
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_col >= NC)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= NR)
        begin
            for (int i = NC; i + NC < NCELL; i++)
                screen[i] = screen[i + NC];
            for (int i = (NR - 1) * NC; i < NCELL; i++)
                screen[i] = SCROLL_FILL;
            cur_row = NR - 1;
        end
    endtask

    task automatic predict_cursor(logic [1:0] op, logic [7:0] c, logic [6:0] pc,
                                  logic [4:0] pr);
        cursor_beat_t e;
        int r;
        e.cell_val = '0;
        case (op_t'(op))
            OP_PUT: print_code(c);
            OP_READ:
                if (pr < NR && pc < NC)
                    e.cell_val = screen[pr * NC + pc];
            OP_CLEAR:
            begin
                for (int i = NC; i < NCELL; i++)
                    screen[i] = blank();
                cur_col = 0;
                cur_row = 1;
            end
            default:
            begin
                cur_col = pc < NC ? pc : NC - 1;
                r = pr;
                if (r < 1) r = 1;
                if (r > NR - 1) r = NR - 1;
                cur_row = r;
            end
        endcase
        e.col = cur_col[6:0];
        e.row = cur_row[4:0];
        e.addr = 11'(cur_row * NC + cur_col);
        expected_q.push_back(e);
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    assign pending = expected_q.size();

    initial
    begin
        fail_count = 0;
        cur_col = 0;
        cur_row = 1;
        regs[0] = 15; regs[1] = 8; regs[2] = 9; regs[3] = 10;
        regs[4] = 128; regs[5] = 129; regs[6] = 130; regs[7] = 131;
    end

    always @(posedge clk)
    begin
        cursor_beat_t e;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                regs[cfg.index] = cfg.data;
            if (out.valid && out.ready)
            begin
                if (expected_q.size() == 0)
                    report("unexpected beat", 0, 0);
                else
                begin
                    e = expected_q.pop_front();
                    if (out.cursor_col !== e.col) report("cursor_col", out.cursor_col, e.col);
                    if (out.cursor_row !== e.row) report("cursor_row", out.cursor_row, e.row);
                    if (out.cursor_addr !== e.addr)
                        report("cursor_addr", out.cursor_addr, e.addr);
                    if (out.cell_value !== e.cell_val)
                        report("cell_value", out.cell_value, e.cell_val);
                end
            end
            if (in.valid && in.ready)
                predict_cursor(in.op, in.char_code, in.pos_col, in.pos_row);
        end
    end
endmodule

// ===== tb/text_console_char_engine_unit_test.sv =====
`timescale 1ns / 1ps
module text_console_char_engine_unit_test;
    import tcce_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    int fail_count;
    int pending;
    int idle_cycles = 0;

    tcce_in_if in_ch();
    tcce_out_if out_ch();
    tcce_cfg_if cfg_ch();

    text_console_char_engine_unit i_dut (.clk(clk), .rst_n(rst_n), .in(in_ch),
                                         .out(out_ch), .cfg(cfg_ch));
    tcce_checker i_chk (.clk(clk), .rst_n(rst_n), .in(in_ch), .out(out_ch),
                        .cfg(cfg_ch), .fail_count(fail_count), .pending(pending));

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // receiver stall pattern
    int stall_mode = 0;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 3) != 0);
            2: out_ch.ready <= ($urandom_range(0, 1) != 0);
            default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("text_console_char_engine_unit_test: errors");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] op, logic [7:0] c, logic [6:0] pc, logic [4:0] pr);
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.char_code <= c;
        in_ch.pos_col <= pc;
        in_ch.pos_row <= pr;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic gap();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        gap();
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [7:0] v);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // reads on the screen only hit rows 1 to 24, which hold a value; other reads fall off the screen
    task automatic random_beat();
        int k;
        int pr;
        int pc;
        k = $urandom_range(0, 99);
        if (k < 60)
        begin
            case ($urandom_range(0, 3))
                0: send_beat(OP_PUT, 8'($urandom), 7'($urandom), 5'($urandom));
                1: send_beat(OP_PUT, 8'($urandom_range(8, 13)), 7'($urandom), 5'($urandom));
                2: send_beat(OP_PUT, 8'($urandom_range(128, 131)), 7'($urandom), 5'($urandom));
                default: send_beat(OP_PUT, 8'($urandom_range(32, 127)), 7'($urandom),
                                   5'($urandom));
            endcase
        end
        else if (k < 80)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                pc = $urandom_range(80, 127);
                pr = $urandom;
                pr = pr % 32;
            end
            else
            begin
                pr = $urandom_range(1, 24);
                pc = $urandom_range(0, 79);
                if ($urandom_range(0, 5) == 0) pr = $urandom_range(25, 31);
            end
            send_beat(OP_READ, 8'($urandom), 7'(pc), 5'(pr));
        end
        else if (k < 83)
            send_beat(OP_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
        else
            send_beat(OP_SET, 8'($urandom), 7'($urandom), 5'($urandom));
    endtask

    task automatic random_phase(int n);
        int burst;
        int sent;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                random_beat();
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                gap();
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
        end
        drain();
    endtask

    initial
    begin
        in_ch.valid = 0;
        in_ch.op = 0;
        in_ch.char_code = 0;
        in_ch.pos_col = 0;
        in_ch.pos_row = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = 0;
        cfg_ch.data = 0;
        out_ch.ready = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // clear first so every cell below row 0 holds a value
        send_beat(OP_CLEAR, 8'h00, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'h20, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'd127, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'hFF, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'd9, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'd8, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'd128, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'd129, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'd131, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'd130, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'd13, 7'd0, 5'd0);
        send_beat(OP_SET, 8'h00, 7'd0, 5'd1);
        send_beat(OP_PUT, 8'd8, 7'd0, 5'd0);
        send_beat(OP_SET, 8'h00, 7'd127, 5'd31);
        send_beat(OP_PUT, 8'h41, 7'd0, 5'd0);
        send_beat(OP_SET, 8'h00, 7'd79, 5'd24);
        send_beat(OP_PUT, 8'd131, 7'd0, 5'd0);
        send_beat(OP_PUT, 8'd10, 7'd0, 5'd0);
        send_beat(OP_SET, 8'h00, 7'd5, 5'd0);
        send_beat(OP_READ, 8'h00, 7'd79, 5'd24);
        send_beat(OP_READ, 8'h00, 7'd0, 5'd1);
        send_beat(OP_READ, 8'hFF, 7'd80, 5'd3);
        send_beat(OP_READ, 8'hFF, 7'd3, 5'd25);
        send_beat(OP_READ, 8'hFF, 7'd127, 5'd31);
        drain();
        random_phase(80);

        write_reg(REG_ATTR, 8'h00);
        write_reg(REG_BS, 8'd127);
        write_reg(REG_TAB, 8'd255);
        write_reg(REG_ENTER, 8'd0);
        write_reg(REG_LEFT, 8'd11);
        write_reg(REG_RIGHT, 8'd12);
        write_reg(REG_HOME, 8'd131);
        write_reg(REG_DEL, 8'd130);
        random_phase(80);

        write_reg(REG_ATTR, 8'hFF);
        write_reg(REG_BS, 8'd0);
        write_reg(REG_TAB, 8'd32);
        write_reg(REG_ENTER, 8'd255);
        write_reg(REG_LEFT, 8'd129);
        write_reg(REG_RIGHT, 8'd128);
        write_reg(REG_HOME, 8'd10);
        write_reg(REG_DEL, 8'd9);
        random_phase(70);

        write_reg(REG_ATTR, 8'($urandom));
        write_reg(REG_BS, 8'd8);
        write_reg(REG_TAB, 8'd9);
        write_reg(REG_ENTER, 8'd10);
        write_reg(REG_LEFT, 8'd128);
        write_reg(REG_RIGHT, 8'd129);
        write_reg(REG_HOME, 8'd130);
        write_reg(REG_DEL, 8'd131);
        random_phase(70);

        if (fail_count == 0)
            $display("text_console_char_engine_unit_test: clean");
        else
            $display("text_console_char_engine_unit_test: errors");
        $finish;
    end
endmodule
